>>> sv/ase_pkg.sv
`default_nettype none
package ase_pkg;

   // default capacity of the value store
   localparam int MAX_ITEMS_DEF = 64;
   localparam int VALUE_W       = 32;

   // one request: a value and the mark that closes the set
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } ase_req_type;

   // one response: the next sorted value and its flags
   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      last_out;
      logic                      dropped;
   } ase_rsp_type;

   // control from the sequencer to the exchange unit
   typedef struct packed {
      logic load;
      logic compare;
   } ase_xchg_ctl_type;

endpackage
`default_nettype wire

>>> sv/ase_store.sv
`default_nettype none
module ase_store #(
   parameter int DEPTH = ase_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]                 wr_addr,
   input  wire logic signed [ase_pkg::VALUE_W-1:0]       wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]                 rd_addr,
   output logic signed [ase_pkg::VALUE_W-1:0]            rd_data
);

   logic signed [ase_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [ase_pkg::VALUE_W-1:0] rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // register the read every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/ase_exchange_unit.sv
`default_nettype none
module ase_exchange_unit (
   input  wire logic                               clock,
   input  wire ase_pkg::ase_xchg_ctl_type          ctl,
   input  wire logic signed [ase_pkg::VALUE_W-1:0] rd_data,
   output logic                                    swap,
   output logic signed [ase_pkg::VALUE_W-1:0]      held_value
);

   logic signed [ase_pkg::VALUE_W-1:0] held_ff;
   logic signed [ase_pkg::VALUE_W-1:0] held_in;

   // signed compare of the held value against the value just read
   assign swap = ctl.compare && (held_ff > rd_data);

   // load the position value, or take the smaller one on a swap
   always_comb begin
      held_in = held_ff;
      if (ctl.load || swap) begin
         held_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   assign held_value = held_ff;

endmodule
`default_nettype wire

>>> sv/ascending_exchange_sorter.sv
// Collecting: one request per cycle, results only after the request marked last.
// Sorting: one compare-swap per cycle in the scan state, through
// a single signed comparator and a one-read, one-write value store.
// Emitting: read, load and wait states per response plus any stall; requests are
// held off from the closing request until the last response is taken.
// Reset (synchronous, active high) clears the count, the drop flag and the sequencer.
`default_nettype none
module ascending_exchange_sorter #(
   parameter int MAX_ITEMS = ase_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ase_pkg::ase_req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ase_pkg::ase_rsp_type       rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   typedef enum logic [7:0] {
      S_COLLECT   = 8'b0000_0001,
      S_START     = 8'b0000_0010,
      S_LOAD_I    = 8'b0000_0100,
      S_SCAN      = 8'b0000_1000,
      S_PUT       = 8'b0001_0000,
      S_EMIT_RD   = 8'b0010_0000,
      S_EMIT_LD   = 8'b0100_0000,
      S_EMIT_WAIT = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [AW-1:0]        i_ff, i_in;
   logic [AW-1:0]        j_ff, j_in;
   logic [AW-1:0]        k_ff, k_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ase_pkg::ase_rsp_type rsp_ff, rsp_in;

   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic signed [ase_pkg::VALUE_W-1:0]   wr_data;
   logic [AW-1:0]                        rd_addr;
   logic signed [ase_pkg::VALUE_W-1:0]   rd_data;
   ase_pkg::ase_xchg_ctl_type            xctl;
   logic                                 swap;
   logic signed [ase_pkg::VALUE_W-1:0]   held_value;

   logic req_accept;
   logic has_room;
   logic j_is_last;
   logic i_is_last;
   logic k_is_last;

   assign req_stall  = (state_ff != S_COLLECT);
   assign req_accept = req_valid && !req_stall;
   assign has_room   = (count_ff < CW'(MAX_ITEMS));
   assign j_is_last  = ((CW'(j_ff) + CW'(1)) == count_ff);
   assign i_is_last  = ((CW'(i_ff) + CW'(2)) == count_ff);
   assign k_is_last  = ((CW'(k_ff) + CW'(1)) == count_ff);

   ase_store #(
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ase_exchange_unit u_xchg (
      .clock      (clock),
      .ctl        (xctl),
      .rd_data    (rd_data),
      .swap       (swap),
      .held_value (held_value)
   );

   // sequence collect, sort and emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_data.value;
      rd_addr      = i_ff;
      xctl.load    = 1'b0;
      xctl.compare = 1'b0;

      unique case (state_ff)
         S_COLLECT: begin
            if (req_accept) begin
               if (has_room) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            rd_addr = '0;
            i_in    = '0;
            k_in    = '0;
            state_in = (count_ff >= CW'(2)) ? S_LOAD_I : S_EMIT_RD;
         end
         S_LOAD_I: begin
            // hold the value at position i, start the scan at i+1
            xctl.load = 1'b1;
            rd_addr   = AW'(i_ff + AW'(1));
            j_in      = AW'(i_ff + AW'(1));
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            xctl.compare = 1'b1;
            if (swap) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = held_value;
            end
            if (j_is_last) begin
               state_in = S_PUT;
            end else begin
               rd_addr = AW'(j_ff + AW'(1));
               j_in    = AW'(j_ff + AW'(1));
            end
         end
         S_PUT: begin
            // write back the minimum found for position i
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = held_value;
            if (i_is_last) begin
               state_in = S_EMIT_RD;
            end else begin
               rd_addr  = AW'(i_ff + AW'(1));
               i_in     = AW'(i_ff + AW'(1));
               state_in = S_LOAD_I;
            end
         end
         S_EMIT_RD: begin
            rd_addr  = k_ff;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            rsp_in.sorted_value = rd_data;
            rsp_in.last_out     = k_is_last;
            rsp_in.dropped      = ovf_ff;
            rsp_valid_in        = 1'b1;
            state_in            = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_COLLECT;
               end else begin
                  k_in     = AW'(k_ff + AW'(1));
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // indexes and response payload
   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("item count beyond capacity");

   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_EMIT_WAIT))
      else $error("response valid outside emit");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (j_ff > i_ff))
      else $error("scan index not beyond position");

   a_close_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last) |=> (state_ff == S_START))
      else $error("closing request did not start sort");

endmodule
`default_nettype wire

>>> tb/tb_ascending_exchange_sorter.sv
`timescale 1ns / 100ps
module tb_ascending_exchange_sorter;

   localparam int CAPACITY         = ase_pkg::MAX_ITEMS_DEF;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS     = 420;
   localparam int TOTAL_ITEMS      = 460;
   localparam int DRAIN_CYCLES     = 100;

   localparam logic signed [ase_pkg::VALUE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [ase_pkg::VALUE_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

   // Track the set being collected and the sorted responses still owed
   class sorted_set_tracker;
      logic signed [ase_pkg::VALUE_W-1:0] held_values[$];
      bit                                 overflow_seen;
      ase_pkg::ase_rsp_type               pending[$];
      int unsigned                        fail_count;

      // Store the request value; on the closing request, sort and queue the responses
      function void note_request(ase_pkg::ase_req_type req);
         logic signed [ase_pkg::VALUE_W-1:0] ordered[$];
         logic signed [ase_pkg::VALUE_W-1:0] swap;
         ase_pkg::ase_rsp_type               rsp;
         int                                 n;
         if (held_values.size() < ase_pkg::MAX_ITEMS_DEF) held_values.push_back(req.value);
         else overflow_seen = 1'b1;
         if (!req.last) return;
         ordered = held_values;
         n = ordered.size();
         // exchange selection: position i against every later j, signed compare
         for (int i = 0; i + 1 < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
               if (ordered[i] > ordered[j]) begin
                  swap       = ordered[i];
                  ordered[i] = ordered[j];
                  ordered[j] = swap;
               end
            end
         end
         for (int k = 0; k < n; k++) begin
            rsp.sorted_value = ordered[k];
            rsp.last_out     = (k == n - 1);
            rsp.dropped      = overflow_seen;
            pending.push_back(rsp);
         end
         held_values.delete();
         overflow_seen = 1'b0;
      endfunction

      // Compare one response against the oldest one owed
      function void check_response(ase_pkg::ase_rsp_type got);
         ase_pkg::ase_rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response sorted_value %0d last_out %0b dropped %0b",
                     $time, got.sorted_value, got.last_out, got.dropped);
            fail_count++;
            return;
         end
         want = pending.pop_front();
         if (got.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value expected %0d, got %0d",
                     $time, want.sorted_value, got.sorted_value);
            fail_count++;
         end
         if (got.last_out !== want.last_out) begin
            $display("%0t: last_out expected %0b, got %0b", $time, want.last_out, got.last_out);
            fail_count++;
         end
         if (got.dropped !== want.dropped) begin
            $display("%0t: dropped expected %0b, got %0b", $time, want.dropped, got.dropped);
            fail_count++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   ase_pkg::ase_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   ase_pkg::ase_rsp_type rsp_data;

   sorted_set_tracker tracker;
   bit                quiet_tail   = 1'b0;
   bit                hold_request = 1'b0;
   int unsigned       cycle_count  = 0;
   int unsigned       items_sent   = 0;

   ascending_exchange_sorter #(.MAX_ITEMS(CAPACITY)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Build a set of random values, biased toward extremes and repeats
   function automatic void fill_random_set(input int size,
                                           output logic signed [ase_pkg::VALUE_W-1:0] vals[$]);
      vals.delete();
      for (int k = 0; k < size; k++) begin
         case ($urandom_range(0, 9))
            0:       vals.push_back(MOST_NEGATIVE);
            1:       vals.push_back(MOST_POSITIVE);
            2, 3:    vals.push_back(32'($urandom_range(0, 15)) - 32'd8);
            default: vals.push_back($urandom());
         endcase
      end
   endfunction

   // Offer one set of requests, the final one marked last
   task automatic send_set(input logic signed [ase_pkg::VALUE_W-1:0] vals[$]);
      bit gaps_on;
      int gap;
      gaps_on = !quiet_tail && ($urandom_range(0, 3) != 0);
      foreach (vals[k]) begin
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= '{value: vals[k], last: (k == vals.size() - 1)};
         do @(posedge clock); while (req_stall !== 1'b0);
         tracker.note_request(req_data);
         items_sent++;
      end
   endtask

   // Hold requests until every owed response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending.size() != 0);
   endtask

   // Take responses; stall in random bursts, calm stretches and one long hold
   initial begin
      int burst_left;
      int calm_left;
      int hold_left;
      bit hold_done;
      burst_left = 0;
      calm_left  = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            tracker.check_response(rsp_data);
         if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) hold_left--;
         else if (burst_left > 0) burst_left--;
         else if (calm_left > 0) calm_left--;
         else if (!quiet_tail) begin
            if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(1, 9);
         end
         rsp_stall <= (hold_left > 0) || (burst_left > 0);
      end
   end

   // Main sequence
   initial begin
      logic signed [ase_pkg::VALUE_W-1:0] vals[$];
      int                                 size;
      int                                 set_index;
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-value sets at both extremes
      vals = {MOST_POSITIVE};
      send_set(vals);
      vals = {MOST_NEGATIVE};
      send_set(vals);
      // mixed signs, extremes and repeated values
      vals = {32'sd5, -32'sd1, 32'sd0, MOST_POSITIVE, MOST_NEGATIVE, -32'sd1, 32'sd5, 32'sd1};
      send_set(vals);
      // descending input, every pair swaps
      vals = {32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2};
      send_set(vals);
      // all values equal
      vals = {32'sd7, 32'sd7, 32'sd7};
      send_set(vals);

      // random sets: the first overflows with the closing request dropped,
      // the second fills the store exactly, the third runs under a long hold
      set_index = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (set_index)
            0: size = CAPACITY + 2;
            1: size = CAPACITY;
            default: begin
               case ($urandom_range(0, 19))
                  0:       size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
                  1:       size = $urandom_range(CAPACITY - 4, CAPACITY);
                  default: size = $urandom_range(1, 12);
               endcase
            end
         endcase
         if (set_index == 2) hold_request <= 1'b1;
         fill_random_set(size, vals);
         send_set(vals);
         set_index++;
         if (set_index == 5 || $urandom_range(0, 9) == 0) wait_for_drain();
      end

      // closing stretch with no idling on either side
      quiet_tail <= 1'b1;
      while (items_sent < TOTAL_ITEMS) begin
         fill_random_set($urandom_range(1, 12), vals);
         send_set(vals);
      end

      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.fail_count == 0 && tracker.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
